>>> rtl/core/hns_pkg.sv
// ----------------------------------------------------------------------------
// hns_pkg
// Shared types and constants of the height-map normal stream.
// ----------------------------------------------------------------------------
package hns_pkg;

   localparam int MAX_COLS   = 256;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int LINES      = 3;
   localparam int LINE_DEPTH = LINES * MAX_COLS;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int ROW_W      = 12;
   localparam int LEN_W      = 9;
   localparam int CNT_W      = 13;
   localparam int CSR_W      = 13;
   localparam int HEIGHT_W   = 16;
   localparam int DIFF_W     = HEIGHT_W + 1;
   localparam int COMP_W     = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_W-1:0] LEN_MIN   = 9'd2;
   localparam logic [LEN_W-1:0] LEN_MAX   = 9'(MAX_COLS);
   localparam logic [LEN_W-1:0] LEN_RESET = 9'd160;
   localparam logic [CNT_W-1:0] CNT_MIN   = 13'd2;
   localparam logic [CNT_W-1:0] CNT_MAX   = 13'd4096;
   localparam logic [CNT_W-1:0] CNT_RESET = 13'd160;

   // register indexes
   localparam logic CSR_ROW_LENGTH = 1'b0;
   localparam logic CSR_ROW_COUNT  = 1'b1;

   typedef logic [1:0] slot_type;

   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         column;
      logic signed [DIFF_W-1:0] dl;
      logic signed [DIFF_W-1:0] dh;
      logic                     last;
   } job_type;

   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         column;
      logic signed [COMP_W-1:0] nx;
      logic signed [COMP_W-1:0] ny;
      logic signed [COMP_W-1:0] nz;
      logic                     last;
   } result_type;

   typedef enum logic [1:0] {FE_IDLE, FE_LR, FE_UD, FE_PUSH} fe_state_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_SQA, BK_SQB, BK_SUM, BK_START, BK_DIV, BK_SQRT, BK_PUSH
   } bk_state_type;

   function automatic slot_type slot_dec(slot_type s);
      return (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

endpackage

>>> rtl/core/hns_front.sv
// ----------------------------------------------------------------------------
// hns_front
// Accepts heights, keeps the three line buffers and turns each sample into
// up to three difference words for the normalize unit.
// ----------------------------------------------------------------------------
module hns_front import hns_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [HEIGHT_W-1:0] req_height,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_data,
   output logic                job_push,
   output job_type             job_data,
   input  logic                job_full
);

   logic [LEN_W-1:0] row_length_ff;
   logic [CNT_W-1:0] row_count_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   slot_type         slot_ff, slot_in;

   fe_state_type state_ff, state_in;

   // item context
   logic [ROW_W-1:0] r_ff;
   logic [COL_W-1:0] c_ff;
   slot_type         s0_ff;
   logic [LEN_W-1:0] len_ff;
   logic             j1_ff, j2_ff, j3_ff;
   logic             j1_in, j2_in, j3_in;
   logic signed [DIFF_W-1:0] dl_ff;

   logic [HEIGHT_W-1:0] line_mem [LINE_DEPTH];
   logic [HEIGHT_W-1:0] rd0_ff, rd1_ff;
   logic [ADDR_W-1:0]   ra0, ra1;

   logic             accept;
   logic [LEN_W-1:0] len;
   logic [CNT_W-1:0] rows;
   logic [COL_W-1:0] lenm1, c;
   logic             last_row;

   // current job
   slot_type         sm1, sm2, lr_slot, up_slot;
   logic [COL_W-1:0] cc, lcol, rcol;
   logic [ROW_W-1:0] job_row;
   logic             job_last, done;

   assign accept   = req_push && !req_full;
   assign req_full = (state_ff != FE_IDLE);

   always_comb begin
      len = row_length_ff;
      if (len < LEN_MIN) len = LEN_MIN;
      if (len > LEN_MAX) len = LEN_MAX;
      rows = row_count_ff;
      if (rows < CNT_MIN) rows = CNT_MIN;
      if (rows > CNT_MAX) rows = CNT_MAX;
      lenm1    = COL_W'(len - 9'd1);
      c        = (col_ff > lenm1) ? lenm1 : col_ff;
      last_row = ({1'b0, row_ff} >= (rows - 13'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= LEN_RESET;
         row_count_ff  <= CNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_LENGTH: row_length_ff <= csr_data[LEN_W-1:0];
            CSR_ROW_COUNT:  row_count_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (accept) begin
         if ({1'b0, c} + 9'd1 >= len) begin
            col_in  = '0;
            row_in  = last_row ? '0 : row_ff + 12'd1;
            slot_in = (last_row || slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
         end else begin
            col_in = c + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // job selection: first pending of the three
   always_comb begin
      sm1 = slot_dec(s0_ff);
      sm2 = slot_dec(sm1);
      if (j1_ff) begin
         cc       = c_ff;
         job_row  = r_ff - 12'd1;
         lr_slot  = sm1;
         up_slot  = (r_ff >= 12'd2) ? sm2 : sm1;
         lcol     = (cc != '0) ? cc - 8'd1 : cc;
         rcol     = ({1'b0, cc} + 9'd1 < len_ff) ? cc + 8'd1 : cc;
         job_last = !(j2_ff || j3_ff);
      end else if (j2_ff) begin
         cc       = c_ff - 8'd1;
         job_row  = r_ff;
         lr_slot  = s0_ff;
         up_slot  = sm1;
         lcol     = (cc != '0) ? cc - 8'd1 : cc;
         rcol     = c_ff;
         job_last = !j3_ff;
      end else begin
         cc       = c_ff;
         job_row  = r_ff;
         lr_slot  = s0_ff;
         up_slot  = sm1;
         lcol     = (cc != '0) ? cc - 8'd1 : cc;
         rcol     = c_ff;
         job_last = 1'b1;
      end
      if (state_ff == FE_LR) begin
         ra0 = {lr_slot, lcol};
         ra1 = {lr_slot, rcol};
      end else begin
         ra0 = {up_slot, cc};
         ra1 = {s0_ff, cc};
      end
   end

   assign job_data.row    = job_row;
   assign job_data.column = cc;
   assign job_data.dl     = dl_ff;
   assign job_data.dh     = DIFF_W'($signed(rd1_ff)) - DIFF_W'($signed(rd0_ff));
   assign job_data.last   = job_last;

   always_comb begin
      state_in = state_ff;
      job_push = 1'b0;
      j1_in    = j1_ff;
      j2_in    = j2_ff;
      j3_in    = j3_ff;
      done     = 1'b0;
      case (state_ff)
         FE_IDLE: begin
            if (accept) begin
               j1_in = (row_ff != '0);
               j2_in = last_row && (c != '0);
               j3_in = last_row && (c == lenm1);
               if (j1_in || j2_in || j3_in) state_in = FE_LR;
            end
         end
         FE_LR:   state_in = FE_UD;
         FE_UD:   state_in = FE_PUSH;
         FE_PUSH: begin
            if (!job_full) begin
               job_push = 1'b1;
               if (j1_ff)      j1_in = 1'b0;
               else if (j2_ff) j2_in = 1'b0;
               else            j3_in = 1'b0;
               done     = job_last;
               state_in = done ? FE_IDLE : FE_LR;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         j1_ff    <= 1'b0;
         j2_ff    <= 1'b0;
         j3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         j1_ff    <= j1_in;
         j2_ff    <= j2_in;
         j3_ff    <= j3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         r_ff   <= row_ff;
         c_ff   <= c;
         s0_ff  <= slot_ff;
         len_ff <= len;
      end
      // right minus left, read data is from the lr phase
      if (state_ff == FE_UD)
         dl_ff <= DIFF_W'($signed(rd1_ff)) - DIFF_W'($signed(rd0_ff));
   end

   always_ff @(posedge clock) begin
      if (accept)
         line_mem[{slot_ff, c}] <= req_height;
      rd0_ff <= line_mem[ra0];
      rd1_ff <= line_mem[ra1];
   end

endmodule

>>> rtl/core/hns_job_queue.sv
// ----------------------------------------------------------------------------
// hns_job_queue
// Small queue of difference words between the front and the normalize unit.
// ----------------------------------------------------------------------------
module hns_job_queue import hns_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   count_ff;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 1'b1;
         if (pop && !empty) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) entry_ff[wr_ff] <= push_data;
   end

endmodule

>>> rtl/core/hns_back.sv
// ----------------------------------------------------------------------------
// hns_back
// Normalize unit: per component a restoring divide of v*v*2^28 by the
// squared length, then a bit-serial square root; results go to a small
// output queue.
// ----------------------------------------------------------------------------
module hns_back import hns_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_empty,
   input  job_type    job_data,
   output logic       job_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output result_type rsp_data
);

   bk_state_type state_ff, state_in;

   job_type      job_ff;
   logic [31:0]  sqa_ff, sqb_ff;
   logic [33:0]  s_ff;
   logic [34:0]  rem_ff;
   logic [28:0]  quo_ff;
   logic [4:0]   cnt_ff;
   logic [3:0]   idx_ff;
   logic [14:0]  m_ff;
   logic [1:0]   comp_ff;
   logic signed [COMP_W-1:0] res_ff [3];

   logic [15:0]  mag;
   logic [32:0]  v2;
   logic [34:0]  shifted;
   logic [14:0]  trial;
   logic [29:0]  trial_sq;
   logic [14:0]  m_next;
   logic         neg;

   result_type        oq_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] oq_wr_ff, oq_rd_ff;
   logic [QPTR_W:0]   oq_count_ff;
   logic              oq_full, oq_push;

   assign oq_full   = (oq_count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign rsp_empty = (oq_count_ff == '0);
   assign rsp_data  = oq_ff[oq_rd_ff];

   always_comb begin
      mag = (state_ff == BK_SQA) ?
            (job_ff.dl[DIFF_W-1] ? 16'(-job_ff.dl) : job_ff.dl[15:0]) :
            (job_ff.dh[DIFF_W-1] ? 16'(-job_ff.dh) : job_ff.dh[15:0]);
      case (comp_ff)
         2'd0:    v2 = {1'b0, sqa_ff};
         2'd1:    v2 = 33'd65536;
         default: v2 = {1'b0, sqb_ff};
      endcase
      case (comp_ff)
         2'd0:    neg = job_ff.dl[DIFF_W-1];
         2'd1:    neg = 1'b1;
         default: neg = job_ff.dh[DIFF_W-1];
      endcase
      shifted  = {rem_ff[33:0], 1'b0};
      trial    = m_ff | (15'd1 << idx_ff);
      trial_sq = trial * trial;
      m_next   = (trial_sq <= {1'b0, quo_ff}) ? trial : m_ff;
   end

   always_comb begin
      state_in = state_ff;
      job_pop  = 1'b0;
      oq_push  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               state_in = BK_SQA;
            end
         end
         BK_SQA:   state_in = BK_SQB;
         BK_SQB:   state_in = BK_SUM;
         BK_SUM:   state_in = BK_START;
         BK_START: state_in = BK_DIV;
         BK_DIV:   if (cnt_ff == 5'd27) state_in = BK_SQRT;
         BK_SQRT: begin
            if (idx_ff == '0) state_in = (comp_ff == 2'd2) ? BK_PUSH : BK_START;
         end
         BK_PUSH: begin
            if (!oq_full) begin
               oq_push  = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE:  if (!job_empty) job_ff <= job_data;
         BK_SQA:   sqa_ff <= mag * mag;
         BK_SQB:   sqb_ff <= mag * mag;
         BK_SUM: begin
            s_ff    <= 34'(sqa_ff) + 34'(sqb_ff) + 34'd65536;
            comp_ff <= 2'd0;
         end
         BK_START: begin
            // integer quotient bit, at most one since v*v never exceeds s
            if ({1'b0, v2} >= {1'b0, s_ff}) begin
               rem_ff <= 35'({1'b0, v2}) - 35'(s_ff);
               quo_ff <= 29'd1;
            end else begin
               rem_ff <= 35'(v2);
               quo_ff <= 29'd0;
            end
            cnt_ff <= '0;
         end
         BK_DIV: begin
            if (shifted >= {1'b0, s_ff}) begin
               rem_ff <= shifted - {1'b0, s_ff};
               quo_ff <= {quo_ff[27:0], 1'b1};
            end else begin
               rem_ff <= shifted;
               quo_ff <= {quo_ff[27:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            m_ff   <= '0;
            idx_ff <= 4'd14;
         end
         BK_SQRT: begin
            m_ff   <= m_next;
            idx_ff <= idx_ff - 4'd1;
            if (idx_ff == '0) begin
               res_ff[comp_ff] <= neg ? -$signed({1'b0, m_next}) : $signed({1'b0, m_next});
               comp_ff <= comp_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         if (oq_push) oq_wr_ff <= oq_wr_ff + 1'b1;
         if (rsp_pop && !rsp_empty) oq_rd_ff <= oq_rd_ff + 1'b1;
         oq_count_ff <= oq_count_ff + (QPTR_W+1)'(oq_push)
                        - (QPTR_W+1)'(rsp_pop && !rsp_empty);
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff].row    <= job_ff.row;
         oq_ff[oq_wr_ff].column <= job_ff.column;
         oq_ff[oq_wr_ff].nx     <= res_ff[0];
         oq_ff[oq_wr_ff].ny     <= res_ff[1];
         oq_ff[oq_wr_ff].nz     <= res_ff[2];
         oq_ff[oq_wr_ff].last   <= job_ff.last;
      end
   end

endmodule

>>> rtl/core/heightmap_normal_stream.sv
// ----------------------------------------------------------------------------
// heightmap_normal_stream
// Raster height samples in, unit surface normals out by central differences.
// Per normal the front does a left/right read, an up/down read and a push,
// then the normalize unit handles three components, each a 29-step divide
// plus a 15-step square root. The front takes no new sample until it has
// pushed all jobs of the last one, and the normalize unit takes no new job
// until its result is pushed. Synchronous reset clears all control state;
// line buffers are not cleared, configuration returns to 160 by 160.
// ----------------------------------------------------------------------------
module heightmap_normal_stream import hns_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [HEIGHT_W-1:0]      req_height,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [ROW_W-1:0]         rsp_row,
   output logic [COL_W-1:0]         rsp_column,
   output logic signed [COMP_W-1:0] rsp_normal_x,
   output logic signed [COMP_W-1:0] rsp_normal_y,
   output logic signed [COMP_W-1:0] rsp_normal_z,
   output logic                     rsp_last_of_run,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   job_type    fq_in, fq_out;
   logic       fq_push, fq_full, fq_pop, fq_empty;
   result_type rsp;

   hns_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_height       (req_height),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .job_push         (fq_push),
      .job_data         (fq_in),
      .job_full         (fq_full)
   );

   hns_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_in),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_out),
      .empty     (fq_empty)
   );

   hns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (fq_empty),
      .job_data  (fq_out),
      .job_pop   (fq_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp)
   );

   assign rsp_row         = rsp.row;
   assign rsp_column      = rsp.column;
   assign rsp_normal_x    = rsp.nx;
   assign rsp_normal_y    = rsp.ny;
   assign rsp_normal_z    = rsp.nz;
   assign rsp_last_of_run = rsp.last;

endmodule
